// ===== hw/rtl/i2p_pkg.sv =====
// shared types, constants and character helpers for the infix to prefix converter
// depends on nothing; imported by i2p_ram users and the top level
package i2p_pkg;

  // expression buffer size and derived widths
  localparam int MAX_LEN = 32;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CHAR_W  = 8;

  // characters with a role in the conversion
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

  // status codes carried on every result
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  // input transaction payload
  typedef struct packed {
    logic [CHAR_W-1:0] symbol;
    logic              last;
  } in_t;

  // result transaction payload
  typedef struct packed {
    logic [CHAR_W-1:0] out_symbol;
    logic              out_last;
    logic              empty_res;
    logic [1:0]        status;
  } out_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH,
    ST_CHAR,
    ST_OPER,
    ST_CLOSE,
    ST_REFILL,
    ST_FLUSH,
    ST_EMIT,
    ST_EOUT
  } state_t;

  // operator precedence, zero for anything else
  function automatic logic [1:0] prec_of(input logic [CHAR_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    case (c)
      CH_CARET:           p = 2'd3;
      CH_STAR, CH_SLASH:  p = 2'd2;
      CH_PLUS, CH_MINUS:  p = 2'd1;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // bracket swap for the reversed scan
  function automatic logic [CHAR_W-1:0] swap_bracket(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c == CH_LPAREN) begin
      r = CH_RPAREN;
    end else if (c == CH_RPAREN) begin
      r = CH_LPAREN;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/infix_to_prefix_converter.sv =====
// Infix to prefix converter. Characters are loaded one per cycle until the
// transaction flagged last; the stored text is then scanned from its end
// (brackets swapped) with an operator stack, and the prefix form is sent out
// one character per result, the final one flagged out_last. Each scanned
// character takes an input store read and a decode, plus a further step for
// an operator push or a closing bracket that finds the stack empty; each pop
// adds a pop step and a refill step that reloads the cached stack top from
// the registered stack ram read. Each result takes an output store read and
// a handoff that waits while the output register is full. A new expression
// can be loaded as soon as the last result sits in the output register. Input
// beyond MAX_LEN characters is dropped with status 1; an unmatched opening
// bracket gives status 2; an empty result gives one item with empty_res set.
// depends on i2p_pkg and i2p_ram
module infix_to_prefix_converter
  import i2p_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // control registers
  state_t            state_r, state_nxt;
  state_t            ret_r, ret_nxt;
  logic [CNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic [1:0]        err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  logic [CHAR_W-1:0] top_r, top_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  out_t              out_data_r, out_data_nxt;

  // memory ports
  logic              in_we, in_re;
  logic [CHAR_W-1:0] in_rdata;
  logic              stk_we, stk_re;
  logic [CHAR_W-1:0] stk_rdata;
  logic              out_we, out_re;
  logic [CHAR_W-1:0] out_rdata;
  logic [CHAR_W-1:0] emit_val;

  logic [CNT_W-1:0]  idx_dec, depth_dec2;
  logic [CHAR_W-1:0] cur_char;
  logic              slot_free, pop_op;

  assign idx_dec    = idx_r - CNT_W'(1);
  assign depth_dec2 = depth_r - CNT_W'(2);
  assign cur_char   = swap_bracket(in_rdata);
  assign slot_free  = !out_valid_r || out_ready;
  assign pop_op     = (prec_of(top_r) > prec_of(char_r)) ||
                      ((prec_of(top_r) == prec_of(char_r)) && (char_r == CH_CARET));

  // expression text
  i2p_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_cnt_r[ADDR_W-1:0]),
    .wdata (in_data.symbol),
    .re    (in_re),
    .raddr (idx_dec[ADDR_W-1:0]),
    .rdata (in_rdata)
  );

  // operator stack, top entry also cached in top_r
  i2p_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[ADDR_W-1:0]),
    .wdata (char_nxt),
    .re    (stk_re),
    .raddr (depth_dec2[ADDR_W-1:0]),
    .rdata (stk_rdata)
  );

  // reversed prefix text
  i2p_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (ocnt_r[ADDR_W-1:0]),
    .wdata (emit_val),
    .re    (out_re),
    .raddr (idx_dec[ADDR_W-1:0]),
    .rdata (out_rdata)
  );

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ret_r       <= ST_FETCH;
      in_cnt_r    <= '0;
      idx_r       <= '0;
      depth_r     <= '0;
      ocnt_r      <= '0;
      err_r       <= STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      in_cnt_r    <= in_cnt_nxt;
      idx_r       <= idx_nxt;
      depth_r     <= depth_nxt;
      ocnt_r      <= ocnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    char_r     <= char_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    in_cnt_nxt    = in_cnt_r;
    idx_nxt       = idx_r;
    depth_nxt     = depth_r;
    ocnt_nxt      = ocnt_r;
    err_nxt       = err_r;
    top_nxt       = top_r;
    char_nxt      = char_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    in_we         = 1'b0;
    in_re         = 1'b0;
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    out_we        = 1'b0;
    out_re        = 1'b0;
    emit_val      = top_r;

    unique case (state_r)
      // collect characters
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cnt_r < CNT_W'(MAX_LEN)) begin
            in_we      = 1'b1;
            in_cnt_nxt = in_cnt_r + CNT_W'(1);
          end else if (err_r == STATUS_OK) begin
            err_nxt = STATUS_TOO_LONG;
          end
          if (in_data.last) begin
            idx_nxt   = in_cnt_nxt;
            state_nxt = ST_FETCH;
          end
        end
      end

      // read next character from the end
      ST_FETCH: begin
        if (idx_r == '0) begin
          state_nxt = ST_FLUSH;
        end else begin
          in_re     = 1'b1;
          state_nxt = ST_CHAR;
        end
      end

      // dispatch on the swapped character
      ST_CHAR: begin
        idx_nxt   = idx_dec;
        char_nxt  = cur_char;
        state_nxt = ST_FETCH;
        if (is_alnum(cur_char)) begin
          emit_val = cur_char;
          if (ocnt_r < CNT_W'(MAX_LEN)) begin
            out_we   = 1'b1;
            ocnt_nxt = ocnt_r + CNT_W'(1);
          end
        end else begin
          case (cur_char)
            CH_LPAREN: begin
              if (depth_r < CNT_W'(MAX_LEN)) begin
                stk_we    = 1'b1;
                top_nxt   = cur_char;
                depth_nxt = depth_r + CNT_W'(1);
              end
            end
            CH_RPAREN: state_nxt = ST_CLOSE;
            default:   state_nxt = ST_OPER;
          endcase
        end
      end

      // pop while the top binds tighter, or equally when the incoming operator is a caret, then push
      ST_OPER: begin
        if ((depth_r != '0) && pop_op) begin
          if (ocnt_r < CNT_W'(MAX_LEN)) begin
            out_we   = 1'b1;
            ocnt_nxt = ocnt_r + CNT_W'(1);
          end
          stk_re    = 1'b1;
          depth_nxt = depth_r - CNT_W'(1);
          ret_nxt   = ST_OPER;
          state_nxt = ST_REFILL;
        end else begin
          if (depth_r < CNT_W'(MAX_LEN)) begin
            stk_we    = 1'b1;
            top_nxt   = char_r;
            depth_nxt = depth_r + CNT_W'(1);
          end
          state_nxt = ST_FETCH;
        end
      end

      // pop down to the opening bracket and drop it
      ST_CLOSE: begin
        if (depth_r == '0) begin
          if (err_r == STATUS_OK) begin
            err_nxt = STATUS_UNDERFLOW;
          end
          state_nxt = ST_FETCH;
        end else begin
          stk_re    = 1'b1;
          depth_nxt = depth_r - CNT_W'(1);
          state_nxt = ST_REFILL;
          if (top_r != CH_LPAREN) begin
            if (ocnt_r < CNT_W'(MAX_LEN)) begin
              out_we   = 1'b1;
              ocnt_nxt = ocnt_r + CNT_W'(1);
            end
            ret_nxt = ST_CLOSE;
          end else begin
            ret_nxt = ST_FETCH;
          end
        end
      end

      // reload the cached top after a pop
      ST_REFILL: begin
        top_nxt   = stk_rdata;
        state_nxt = ret_r;
      end

      // empty the stack into the output store
      ST_FLUSH: begin
        if (depth_r != '0) begin
          if (ocnt_r < CNT_W'(MAX_LEN)) begin
            out_we   = 1'b1;
            ocnt_nxt = ocnt_r + CNT_W'(1);
          end
          stk_re    = 1'b1;
          depth_nxt = depth_r - CNT_W'(1);
          ret_nxt   = ST_FLUSH;
          state_nxt = ST_REFILL;
        end else begin
          idx_nxt   = ocnt_r;
          state_nxt = ST_EMIT;
        end
      end

      // issue output store read, or send the empty marker
      ST_EMIT: begin
        if (idx_r == '0) begin
          if (slot_free) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.out_symbol = CH_NUL;
            out_data_nxt.out_last   = 1'b1;
            out_data_nxt.empty_res  = 1'b1;
            out_data_nxt.status     = err_r;
            in_cnt_nxt              = '0;
            ocnt_nxt                = '0;
            err_nxt                 = STATUS_OK;
            state_nxt               = ST_LOAD;
          end
        end else begin
          out_re    = 1'b1;
          state_nxt = ST_EOUT;
        end
      end

      // hand one prefix character to the output register
      ST_EOUT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_symbol = out_rdata;
          out_data_nxt.out_last   = (idx_r == CNT_W'(1));
          out_data_nxt.empty_res  = 1'b0;
          out_data_nxt.status     = err_r;
          idx_nxt                 = idx_dec;
          if (idx_r == CNT_W'(1)) begin
            in_cnt_nxt = '0;
            ocnt_nxt   = '0;
            err_nxt    = STATUS_OK;
            state_nxt  = ST_LOAD;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end

      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // stack never grows past the buffer
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(MAX_LEN))
    else $error("operator stack depth out of range");

  // every emitted character came from a stored one
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= in_cnt_r)
    else $error("output count exceeds input count");

  // loading starts from a clean stack and output store
  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> ((ocnt_r == '0) && (depth_r == '0)))
    else $error("counts not cleared before loading");

  // an empty marker is always the final result
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.empty_res) |-> out_data_r.out_last)
    else $error("empty marker without last flag");

  // refill always returns to a pop loop or the scan
  a_refill_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REFILL) |-> ((ret_r == ST_OPER) || (ret_r == ST_CLOSE) ||
                                (ret_r == ST_FLUSH) || (ret_r == ST_FETCH)))
    else $error("bad return state after stack refill");
`endif

endmodule

// ===== hw/rtl/i2p_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
